>>> rtl/apu_fsle_pkg.sv
// ---------------------------------------------------------------------------
// apu_fsle_pkg
// Types and constants for the audio frame sequencer, length counter and
// volume envelope block.
// ---------------------------------------------------------------------------
package apu_fsle_pkg;

  localparam int STEP_COUNT  = 8;
  localparam int STEP_W      = 3;
  localparam int LENGTH_W    = 9;
  localparam int VOLUME_W    = 4;
  localparam int TIMER_W     = 4;
  localparam int PERIOD_W    = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [STEP_W-1:0]   STEP_LAST      = STEP_W'(STEP_COUNT - 1);
  localparam logic [STEP_W-1:0]   STEP_ENVELOPE  = 3'd7;
  localparam logic [STEP_W-1:0]   STEP_SWEEP_LO  = 3'd2;
  localparam logic [STEP_W-1:0]   STEP_SWEEP_HI  = 3'd6;
  localparam logic [LENGTH_W-1:0] LENGTH_CAP     = 9'd256;
  localparam logic [LENGTH_W-1:0] LENGTH_MIN     = 9'd1;
  localparam logic [LENGTH_W-1:0] LENGTH_RST     = 9'd64;
  localparam logic [VOLUME_W-1:0] VOLUME_MAX     = 4'hF;
  localparam logic [TIMER_W-1:0]  ENV_RELOAD_DEF = 4'd8;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_CTRL      = 2'd1,
    FUNC_LOAD      = 2'd2,
    FUNC_POWER_OFF = 2'd3
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LENGTH_MAX   = 3'd0,
    CFG_ENV_PERIOD   = 3'd1,
    CFG_ENV_INCREASE = 3'd2,
    CFG_START_VOLUME = 3'd3,
    CFG_DAC_ON       = 3'd4
  } cfg_index_t;

  typedef struct packed {
    func_t                func;
    logic                 length_enable;
    logic                 restart;
    logic [LENGTH_W-1:0]  length_value;
  } in_item_t;

  typedef struct packed {
    logic                 channel_on;
    logic [VOLUME_W-1:0]  volume_out;
    logic [LENGTH_W-1:0]  length_left;
    logic [STEP_W-1:0]    step_out;
    logic                 sweep_clock;
  } out_item_t;

endpackage

>>> rtl/apu_frame_sequencer_length_envelope.sv
// ---------------------------------------------------------------------------
// apu_frame_sequencer_length_envelope
// Frame sequencer, length counter and volume envelope of one sound channel.
// ---------------------------------------------------------------------------
//  channel | ports                         | moves
//  --------+-------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data   | one item: tick/ctrl/load/off
//  out     | out_valid, out_ready, out_data| one status item per input item
//  cfg     | cfg_valid, cfg_ready,         | one register write
//          | cfg_index, cfg_data           |
//
//  Items pass the item register, then the result register; one item per cycle
//  while out_ready is high. Channel state and result register update as an
//  item leaves the item register. A stalled result holds the item register
//  behind it; the input side stalls only when both are full. cfg_ready is always high.
//  Synchronous reset clears state but sets length max 64, envelope active.
// ---------------------------------------------------------------------------
module apu_frame_sequencer_length_envelope (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  apu_fsle_pkg::in_item_t                    in_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output apu_fsle_pkg::out_item_t                   out_data,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [apu_fsle_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [apu_fsle_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [apu_fsle_pkg::LENGTH_W-1:0] length_max_r;
  logic [apu_fsle_pkg::PERIOD_W-1:0] env_period_r;
  logic                              env_increase_r;
  logic [apu_fsle_pkg::VOLUME_W-1:0] start_volume_r;
  logic                              dac_on_r;

  logic [apu_fsle_pkg::STEP_W-1:0]   seq_step_r,       seq_step_nxt;
  logic [apu_fsle_pkg::LENGTH_W-1:0] length_count_r,   length_count_nxt;
  logic                              length_on_r,      length_on_nxt;
  logic [apu_fsle_pkg::VOLUME_W-1:0] volume_level_r,   volume_level_nxt;
  logic                              env_active_r,     env_active_nxt;
  logic [apu_fsle_pkg::TIMER_W-1:0]  env_timer_r,      env_timer_nxt;
  logic                              channel_active_r, channel_active_nxt;

  logic                              item_valid_r;
  apu_fsle_pkg::in_item_t            item_r;
  logic                              out_valid_r;
  apu_fsle_pkg::out_item_t           out_data_r;

  logic                              in_fire;
  logic                              res_free;
  logic                              proc_fire;
  logic                              cfg_fire;
  logic                              sweep;
  logic [apu_fsle_pkg::LENGTH_W-1:0] length_reload;
  logic [apu_fsle_pkg::TIMER_W-1:0]  env_reload;
  apu_fsle_pkg::out_item_t           result;

  assign res_free  = !out_valid_r || out_ready;
  assign proc_fire = item_valid_r && res_free;
  assign in_ready  = !item_valid_r || res_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign length_reload = (length_max_r == '0) ? apu_fsle_pkg::LENGTH_MIN :
                         (length_max_r > apu_fsle_pkg::LENGTH_CAP) ?
                         apu_fsle_pkg::LENGTH_CAP : length_max_r;
  assign env_reload    = (env_period_r == '0) ? apu_fsle_pkg::ENV_RELOAD_DEF :
                         {1'b0, env_period_r};

  always_comb begin
    seq_step_nxt       = seq_step_r;
    length_count_nxt   = length_count_r;
    length_on_nxt      = length_on_r;
    volume_level_nxt   = volume_level_r;
    env_active_nxt     = env_active_r;
    env_timer_nxt      = env_timer_r;
    channel_active_nxt = channel_active_r;
    sweep              = 1'b0;
    if (proc_fire) begin
      unique case (item_r.func)
        apu_fsle_pkg::FUNC_TICK: begin
          if (!seq_step_r[0] && length_on_r && (length_count_r != '0)) begin
            length_count_nxt = length_count_r - 9'd1;
            if (length_count_nxt == '0) begin
              channel_active_nxt = 1'b0;
            end
          end
          if (seq_step_r == apu_fsle_pkg::STEP_ENVELOPE) begin
            if (env_timer_r != '0) begin
              env_timer_nxt = env_timer_r - 4'd1;
            end
            if (env_timer_nxt == '0) begin
              env_timer_nxt = env_reload;
              if (env_active_r && (env_period_r != '0)) begin
                if (env_increase_r) begin
                  if (volume_level_r < apu_fsle_pkg::VOLUME_MAX) begin
                    volume_level_nxt = volume_level_r + 4'd1;
                  end
                end else if (volume_level_r != '0) begin
                  volume_level_nxt = volume_level_r - 4'd1;
                end
                if ((volume_level_nxt == '0) ||
                    (volume_level_nxt == apu_fsle_pkg::VOLUME_MAX)) begin
                  env_active_nxt = 1'b0;
                end
              end
            end
          end
          sweep        = (seq_step_r == apu_fsle_pkg::STEP_SWEEP_LO) ||
                         (seq_step_r == apu_fsle_pkg::STEP_SWEEP_HI);
          seq_step_nxt = (seq_step_r == apu_fsle_pkg::STEP_LAST) ? '0 :
                         seq_step_r + 3'd1;
        end
        apu_fsle_pkg::FUNC_CTRL: begin
          length_on_nxt = item_r.length_enable;
          if (!length_on_r && item_r.length_enable && seq_step_r[0] &&
              (length_count_r != '0)) begin
            length_count_nxt = length_count_r - 9'd1;
            if (length_count_nxt == '0) begin
              channel_active_nxt = 1'b0;
            end
          end
          if (item_r.restart) begin
            channel_active_nxt = dac_on_r;
            if (length_count_nxt == '0) begin
              length_count_nxt = length_reload;
              if (seq_step_r[0] && length_on_nxt) begin
                length_count_nxt = length_reload - 9'd1;
                if (length_count_nxt == '0) begin
                  channel_active_nxt = 1'b0;
                end
              end
            end
            volume_level_nxt = start_volume_r;
            env_timer_nxt    = env_reload;
            env_active_nxt   = 1'b1;
          end
        end
        apu_fsle_pkg::FUNC_LOAD: begin
          length_count_nxt = (item_r.length_value > apu_fsle_pkg::LENGTH_CAP) ?
                             apu_fsle_pkg::LENGTH_CAP : item_r.length_value;
        end
        apu_fsle_pkg::FUNC_POWER_OFF: begin
          seq_step_nxt = '0;
        end
        default: begin
          seq_step_nxt = seq_step_r;
        end
      endcase
      if (!dac_on_r) begin
        channel_active_nxt = 1'b0;
      end
    end
    if (cfg_fire && (cfg_index == apu_fsle_pkg::CFG_DAC_ON) && !cfg_data[0]) begin
      channel_active_nxt = 1'b0;
    end
  end

  always_comb begin
    result.channel_on  = channel_active_nxt;
    result.volume_out  = volume_level_nxt;
    result.length_left = length_count_nxt;
    result.step_out    = seq_step_nxt;
    result.sweep_clock = sweep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_max_r   <= apu_fsle_pkg::LENGTH_RST;
      env_period_r   <= '0;
      env_increase_r <= 1'b0;
      start_volume_r <= '0;
      dac_on_r       <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        apu_fsle_pkg::CFG_LENGTH_MAX:   length_max_r   <= cfg_data;
        apu_fsle_pkg::CFG_ENV_PERIOD:   env_period_r   <= cfg_data[2:0];
        apu_fsle_pkg::CFG_ENV_INCREASE: env_increase_r <= cfg_data[0];
        apu_fsle_pkg::CFG_START_VOLUME: start_volume_r <= cfg_data[3:0];
        apu_fsle_pkg::CFG_DAC_ON:       dac_on_r       <= cfg_data[0];
        default: begin
          dac_on_r <= dac_on_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_step_r       <= '0;
      length_count_r   <= '0;
      length_on_r      <= 1'b0;
      volume_level_r   <= '0;
      env_active_r     <= 1'b1;
      env_timer_r      <= '0;
      channel_active_r <= 1'b0;
      item_valid_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      seq_step_r       <= seq_step_nxt;
      length_count_r   <= length_count_nxt;
      length_on_r      <= length_on_nxt;
      volume_level_r   <= volume_level_nxt;
      env_active_r     <= env_active_nxt;
      env_timer_r      <= env_timer_nxt;
      channel_active_r <= channel_active_nxt;
      if (in_fire) begin
        item_valid_r <= 1'b1;
      end else if (proc_fire) begin
        item_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    if (proc_fire) begin
      out_data_r <= result;
    end
  end

endmodule

>>> rtl/apu_fsle_checker.sv
// ---------------------------------------------------------------------------
// apu_fsle_checker
// Port-level checks for the frame sequencer, length and envelope block.
// ---------------------------------------------------------------------------
module apu_fsle_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  apu_fsle_pkg::out_item_t              out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // sweep pulse only after a tick from step 2 or 6
  a_sweep_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sweep_clock |->
      (out_data.step_out == 3'd3) || (out_data.step_out == 3'd7))
    else $error("sweep pulse on wrong step");

  a_length_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length_left <= apu_fsle_pkg::LENGTH_CAP)
    else $error("length count above cap");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending after reset");

endmodule

bind apu_frame_sequencer_length_envelope apu_fsle_checker u_apu_fsle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
